// ----- rtl/ihs_pkg.sv -----
// Package: constants and helpers shared by the IPv4 header scanner files.
package ihs_pkg;

  // Trigger pattern: Ethernet type 0x0800 followed by version/IHL 0x45
  localparam logic [7:0] PAT_FIRST  = 8'h08;
  localparam logic [7:0] PAT_SECOND = 8'h00;
  localparam logic [7:0] PAT_THIRD  = 8'h45;

  // Header geometry
  localparam logic [3:0] IHL_MIN      = 4'd5;
  localparam logic [5:0] HDR_BYTES_MIN = 6'd20;

  // Byte offsets of captured fields inside the header
  localparam logic [5:0] OFS_LEN_HI  = 6'd2;
  localparam logic [5:0] OFS_LEN_LO  = 6'd3;
  localparam logic [5:0] OFS_SRC_LO  = 6'd12;
  localparam logic [5:0] OFS_SRC_HI  = 6'd15;
  localparam logic [5:0] OFS_DST_LO  = 6'd16;
  localparam logic [5:0] OFS_DST_HI  = 6'd19;

  localparam logic [15:0] SUM_ONES  = 16'hFFFF;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Pattern match progress
  typedef enum logic [1:0] {
    MATCH_HUNT = 2'd0,
    MATCH_08   = 2'd1,
    MATCH_0800 = 2'd2
  } ihs_match_e;

  // Ones' complement add of one 16-bit word with end-around carry
  function automatic logic [16:0] add_word(input logic [16:0] acc, input logic [15:0] word);
    logic [17:0] s;
    s = {1'b0, acc} + {2'b00, word};
    return {1'b0, s[15:0]} + {15'd0, s[17:16]};
  endfunction

endpackage

// ----- rtl/ihs_stream_if.sv -----
// Interfaces: valid/ready channels for input bytes and header results.
interface ihs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
  modport mon    (input valid, input data_byte, input end_of_stream, input ready);
endinterface

interface ihs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [15:0] total_length;
  logic        header_ok;
  logic [31:0] bad_header_count;

  modport source (output valid, output source_address, output destination_address,
                  output total_length, output header_ok, output bad_header_count,
                  input ready);
  modport sink   (input valid, input source_address, input destination_address,
                  input total_length, input header_ok, input bad_header_count,
                  output ready);
  modport mon    (input valid, input source_address, input destination_address,
                  input total_length, input header_ok, input bad_header_count,
                  input ready);
endinterface

// ----- rtl/ipv4_header_scanner_unit.sv -----
// Top level: byte-stream IPv4 header finder with checksum verification.
// Result: a result appears in the output register in the cycle after the transfer
//   of the last header byte.
// Throughput: one byte per cycle; input is held off only while a result waits
//   in the output register and the sink is not ready.
// Reset (rst_ni low, asynchronous): scanner hunts for 08 00 45, bad count zero.
module ipv4_header_scanner_unit
  import ihs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ihs_in_if.sink     in_i,
  ihs_out_if.source  out_o
);

  // Scanner state
  ihs_match_e  match_q, match_d;
  logic        capt_q, capt_d;
  logic [5:0]  idx_q, idx_d;
  logic [5:0]  need_q, need_d;
  logic [16:0] sum_q, sum_d;
  logic [7:0]  hold_q, hold_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [15:0] len_q, len_d;
  logic [31:0] bad_q, bad_d;

  // Output register
  logic        ovalid_q, ovalid_d;
  logic [31:0] osrc_q, odst_q, obad_q;
  logic [15:0] olen_q;
  logic        ook_q;

  logic        in_fire;
  logic [7:0]  b;
  logic        start;
  logic        cap;
  logic [5:0]  idx_eff, need_eff, need_new;
  logic [16:0] sum_base, sum_new;
  logic [31:0] src_base, dst_base;
  logic [15:0] len_base;
  logic [6:0]  idx_next;
  logic        last;
  logic        ok;

  assign b       = in_i.data_byte;
  assign in_i.ready = !ovalid_q || out_o.ready;
  assign in_fire = in_i.valid && in_i.ready;

  // Pattern match next state (only advanced while not capturing)
  always_comb begin
    match_d = match_q;
    if (!capt_q) begin
      unique case (match_q)
        MATCH_0800: begin
          if (b == PAT_THIRD) match_d = MATCH_HUNT;
          else match_d = (b == PAT_FIRST) ? MATCH_08 : MATCH_HUNT;
        end
        MATCH_08: begin
          if (b == PAT_SECOND) match_d = MATCH_0800;
          else match_d = (b == PAT_FIRST) ? MATCH_08 : MATCH_HUNT;
        end
        MATCH_HUNT: match_d = (b == PAT_FIRST) ? MATCH_08 : MATCH_HUNT;
        default:    match_d = MATCH_HUNT;
      endcase
    end
  end

  // Pattern match output: header start on the trigger byte
  always_comb begin
    start = 1'b0;
    if (!capt_q) begin
      unique case (match_q)
        MATCH_0800: start = (b == PAT_THIRD);
        default:    start = 1'b0;
      endcase
    end
  end

  // Header length from IHL, never below five words
  assign need_new = (b[3:0] < IHL_MIN) ? HDR_BYTES_MIN : {b[3:0], 2'b00};

  // Effective capture context for this byte
  assign cap      = capt_q || start;
  assign idx_eff  = start ? 6'd0 : idx_q;
  assign need_eff = start ? need_new : need_q;
  assign sum_base = start ? 17'd0 : sum_q;
  assign src_base = start ? 32'd0 : src_q;
  assign dst_base = start ? 32'd0 : dst_q;
  assign len_base = start ? 16'd0 : len_q;
  assign idx_next = {1'b0, idx_eff} + 7'd1;
  assign last     = cap && (idx_next >= {1'b0, need_eff});

  // Checksum word completes on odd byte offsets
  assign sum_new = idx_eff[0] ? add_word(sum_base, {hold_q, b}) : sum_base;
  assign ok      = (sum_new[15:0] == SUM_ONES) || (sum_new[15:0] == 16'd0);

  // Next scanner state
  always_comb begin
    capt_d = capt_q;
    idx_d  = idx_q;
    need_d = need_q;
    sum_d  = sum_q;
    hold_d = hold_q;
    src_d  = src_q;
    dst_d  = dst_q;
    len_d  = len_q;
    bad_d  = bad_q;
    if (cap) begin
      // field capture
      src_d = src_base;
      dst_d = dst_base;
      len_d = len_base;
      if (idx_eff == OFS_LEN_HI || idx_eff == OFS_LEN_LO) begin
        len_d = {len_base[7:0], b};
      end else if (idx_eff >= OFS_SRC_LO && idx_eff <= OFS_SRC_HI) begin
        src_d = {src_base[23:0], b};
      end else if (idx_eff >= OFS_DST_LO && idx_eff <= OFS_DST_HI) begin
        dst_d = {dst_base[23:0], b};
      end
      if (!idx_eff[0]) hold_d = b;
      if (last) begin
        if (!ok && bad_q != COUNT_MAX) bad_d = bad_q + 32'd1;
        capt_d = 1'b0;
        idx_d  = 6'd0;
        need_d = HDR_BYTES_MIN;
        sum_d  = 17'd0;
        hold_d = 8'd0;
      end else begin
        capt_d = 1'b1;
        idx_d  = idx_next[5:0];
        need_d = need_eff;
        sum_d  = sum_new;
      end
    end
    // end of stream drops any partial header
    if (in_i.end_of_stream) begin
      capt_d = 1'b0;
      idx_d  = 6'd0;
      need_d = HDR_BYTES_MIN;
      sum_d  = 17'd0;
      hold_d = 8'd0;
    end
  end

  // Output valid: load on a finished header, drop on transfer
  always_comb begin
    ovalid_d = ovalid_q;
    if (in_fire && last) ovalid_d = 1'b1;
    else if (out_o.ready) ovalid_d = 1'b0;
  end

  // Scanner and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q  <= MATCH_HUNT;
      capt_q   <= 1'b0;
      idx_q    <= 6'd0;
      need_q   <= HDR_BYTES_MIN;
      sum_q    <= 17'd0;
      hold_q   <= 8'd0;
      src_q    <= 32'd0;
      dst_q    <= 32'd0;
      len_q    <= 16'd0;
      bad_q    <= 32'd0;
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      if (in_fire) begin
        match_q <= in_i.end_of_stream ? MATCH_HUNT : match_d;
        capt_q  <= capt_d;
        idx_q   <= idx_d;
        need_q  <= need_d;
        sum_q   <= sum_d;
        hold_q  <= hold_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
        len_q   <= len_d;
        bad_q   <= bad_d;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    if (in_fire && last) begin
      osrc_q <= src_d;
      odst_q <= dst_d;
      olen_q <= len_d;
      ook_q  <= ok;
      obad_q <= bad_d;
    end
  end

  assign out_o.valid               = ovalid_q;
  assign out_o.source_address      = osrc_q;
  assign out_o.destination_address = odst_q;
  assign out_o.total_length        = olen_q;
  assign out_o.header_ok           = ook_q;
  assign out_o.bad_header_count    = obad_q;

endmodule

// ----- rtl/ihs_checker.sv -----
// Checker: port-level assertions for the IPv4 header scanner, bound to the top.
module ihs_checker
  import ihs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  ihs_in_if.sink     in_i,
  ihs_out_if.source  out_o
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.source_address)
      && $stable(out_o.bad_header_count) && $stable(out_o.header_ok))
    else $error("result changed while stalled");

  // A new result only follows an input transfer
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(in_i.valid && in_i.ready))
    else $error("result without input transfer");

  // Input is only held off by a stalled result
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input stalled without output backpressure");

  // A failed header is always counted
  a_bad_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.header_ok |-> out_o.bad_header_count != 32'd0)
    else $error("bad header not counted");

endmodule

bind ipv4_header_scanner_unit ihs_checker u_ihs_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);

// ----- test/testbench.sv -----
// Testbench: IPv4 header scanner driven with byte streams and checked against a local predictor.
module testbench
  import ihs_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 150;
  localparam int ITEM_TARGET    = 750;
  localparam int CALM_AFTER     = 600;

  // One header result as seen on the output channel
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] len;
    logic        ok;
    logic [31:0] bad;
  } hdr_result_t;

  // Mirrors the scanner and holds the headers it should report
  class header_scoreboard;
    ihs_match_e  stage;
    bit          in_header;
    bit [5:0]    byte_pos;
    bit [5:0]    hdr_len;
    bit [16:0]   csum;
    bit [7:0]    hi_byte;
    bit [31:0]   src_acc;
    bit [31:0]   dst_acc;
    bit [15:0]   len_acc;
    bit [31:0]   bad_total;
    hdr_result_t expected_q[$];
    int          errors;
    int          produced;

    function new();
      bad_total = '0;
      src_acc   = '0;
      dst_acc   = '0;
      len_acc   = '0;
      errors    = 0;
      produced  = 0;
      restart_hunt();
    endfunction

    function void restart_hunt();
      stage     = MATCH_HUNT;
      in_header = 1'b0;
      byte_pos  = '0;
      hdr_len   = HDR_BYTES_MIN;
      csum      = '0;
      hi_byte   = '0;
    endfunction

    // Called for every accepted input transfer
    function void note_byte(bit [7:0] b, bit eos);
      hdr_result_t r;
      bit [3:0]    ihl;
      bit [17:0]   t;
      // pattern hunt, overlapping matches restart on 0x08
      if (!in_header) begin
        if (stage == MATCH_0800 && b == PAT_THIRD) begin
          stage = MATCH_HUNT;
          ihl = b[3:0];
          if (ihl < IHL_MIN) ihl = IHL_MIN;
          hdr_len   = {ihl, 2'b00};
          in_header = 1'b1;
          byte_pos  = '0;
          csum      = '0;
          src_acc   = '0;
          dst_acc   = '0;
          len_acc   = '0;
        end else if (stage == MATCH_08 && b == PAT_SECOND) begin
          stage = MATCH_0800;
        end else begin
          stage = (b == PAT_FIRST) ? MATCH_08 : MATCH_HUNT;
        end
      end
      // header capture and ones' complement sum
      if (in_header) begin
        if (byte_pos == OFS_LEN_HI || byte_pos == OFS_LEN_LO)
          len_acc = {len_acc[7:0], b};
        else if (byte_pos >= OFS_SRC_LO && byte_pos <= OFS_SRC_HI)
          src_acc = {src_acc[23:0], b};
        else if (byte_pos >= OFS_DST_LO && byte_pos <= OFS_DST_HI)
          dst_acc = {dst_acc[23:0], b};
        if (!byte_pos[0]) begin
          hi_byte = b;
        end else begin
          t    = {1'b0, csum} + {2'b00, hi_byte, b};
          csum = t[15:0] + t[17:16];
        end
        if (int'(byte_pos) + 1 >= int'(hdr_len)) begin
          r.ok = (csum[15:0] == SUM_ONES) || (csum[15:0] == 16'h0000);
          if (!r.ok && bad_total != COUNT_MAX) bad_total++;
          r.src = src_acc;
          r.dst = dst_acc;
          r.len = len_acc;
          r.bad = bad_total;
          expected_q = {expected_q, r};
          produced++;
          restart_hunt();
        end else begin
          byte_pos++;
        end
      end
      // end of stream drops any partial header
      if (eos) restart_hunt();
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t mismatch %s expected %h actual %h", $time, field, want, got);
      end
    endfunction

    // Called for every accepted output transfer
    function void check_result(hdr_result_t got);
      hdr_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result expected none actual %h", $time, got);
      end else begin
        want = expected_q.pop_front();
        compare_field("source_address", want.src, got.src);
        compare_field("destination_address", want.dst, got.dst);
        compare_field("total_length", 32'(want.len), 32'(got.len));
        compare_field("header_ok", 32'(want.ok), 32'(got.ok));
        compare_field("bad_header_count", want.bad, got.bad);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ihs_in_if  in_bus ();
  ihs_out_if out_bus ();

  ipv4_header_scanner_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  header_scoreboard sb;
  hdr_result_t      seen_result;
  bit [7:0]         hdr_buf [0:19];
  bit               idle_in_en;
  bit               idle_out_en;
  int               in_idle_pct;
  bit               hold_req;
  bit               hold_taken;
  int               stall_left;
  int               quiet_cycles;
  int               sent_items;

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver: random stall bursts plus one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      stall_left = LONG_HOLD;
    end else if (stall_left == 0 && idle_out_en && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 15);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Monitor: both channels sampled at the edge, plus the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        sb.note_byte(in_bus.data_byte, in_bus.end_of_stream);
      if (out_bus.valid && out_bus.ready) begin
        seen_result.src = out_bus.source_address;
        seen_result.dst = out_bus.destination_address;
        seen_result.len = out_bus.total_length;
        seen_result.ok  = out_bus.header_ok;
        seen_result.bad = out_bus.bad_header_count;
        sb.check_result(seen_result);
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // One input transfer, optionally preceded by an idle burst
  task automatic send_byte(input bit [7:0] b, input bit eos);
    if (idle_in_en && $urandom_range(0, 99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.data_byte     <= b;
    in_bus.end_of_stream <= eos;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sent_items++;
  endtask

  // Set bytes 10..11 so the header sums to all ones
  function automatic void seal_checksum();
    bit [31:0] s;
    s = '0;
    hdr_buf[10] = '0;
    hdr_buf[11] = '0;
    for (int i = 0; i < 20; i += 2) s += {hdr_buf[i], hdr_buf[i+1]};
    s = s[15:0] + s[31:16];
    s = s[15:0] + s[31:16];
    {hdr_buf[10], hdr_buf[11]} = ~s[15:0];
  endfunction

  // Trigger prefix followed by the header buffer; eos_at < 0 means no end flag
  task automatic send_header(input int eos_at);
    send_byte(PAT_FIRST, 1'b0);
    send_byte(PAT_SECOND, 1'b0);
    for (int i = 0; i < 20; i++) send_byte(hdr_buf[i], i == eos_at);
  endtask

  // Filler bytes, biased toward pattern bytes to form broken matches
  task automatic send_noise(input int n);
    bit [7:0] b;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 4))
        0:       b = PAT_FIRST;
        1:       b = PAT_SECOND;
        2:       b = PAT_THIRD;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b, $urandom_range(0, 29) == 0);
    end
  endtask

  initial begin
    int eos_at;
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.data_byte     = '0;
    in_bus.end_of_stream = 1'b0;
    out_bus.ready        = 1'b0;
    idle_in_en           = 1'b0;
    idle_out_en          = 1'b0;
    in_idle_pct          = 0;
    hold_req             = 1'b0;
    hold_taken           = 1'b0;
    stall_left           = 0;
    quiet_cycles         = 0;
    sent_items           = 0;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_in_en  = 1'b1;
    idle_out_en = 1'b1;
    in_idle_pct = 10;

    // Directed: overlapping 08 08 00 45, good header with extreme field values
    for (int i = 0; i < 20; i++) hdr_buf[i] = 8'h00;
    hdr_buf[0] = PAT_THIRD;
    hdr_buf[2] = 8'hFF;
    hdr_buf[3] = 8'hFF;
    for (int i = 12; i < 16; i++) hdr_buf[i] = 8'hFF;
    seal_checksum();
    send_byte(PAT_FIRST, 1'b0);
    send_header(-1);
    // end of stream on the trigger byte drops the header before it starts
    send_byte(PAT_FIRST, 1'b0);
    send_byte(PAT_SECOND, 1'b0);
    send_byte(PAT_THIRD, 1'b1);

    // Random: mostly well-formed headers, some broken prefixes and aborts
    hold_req <= 1'b1;
    while (sent_items < ITEM_TARGET) begin
      if (sent_items > CALM_AFTER) begin
        idle_in_en  = 1'b0;
        idle_out_en = 1'b0;
      end
      case ($urandom_range(0, 2))
        0:       in_idle_pct = 0;
        1:       in_idle_pct = 4;
        default: in_idle_pct = 25;
      endcase
      send_noise($urandom_range(0, 5));
      if ($urandom_range(0, 7) == 0) begin
        send_byte(PAT_FIRST, 1'b0);
        send_byte($urandom_range(0, 1) ? PAT_SECOND : 8'($urandom_range(0, 255)), 1'b0);
      end else begin
        for (int i = 0; i < 20; i++) hdr_buf[i] = 8'($urandom_range(0, 255));
        hdr_buf[0] = PAT_THIRD;
        if ($urandom_range(0, 2) != 0) seal_checksum();
        eos_at = -1;
        if ($urandom_range(0, 9) == 0)
          eos_at = ($urandom_range(0, 2) == 0) ? 19 : $urandom_range(0, 19);
        send_header(eos_at);
      end
    end
    in_bus.valid <= 1'b0;

    // Drain: watchdog covers a missing result
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
